>>> src/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Infix-to-postfix converter package
// Character codes, command classes, operator ranks and the command beat that
// travels from the classifying front end to the stack back end.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Default operator stack depth.
   localparam int DEF_STACK_DEPTH = 32;

   // Command queue between front and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QAW         = $clog2(QUEUE_DEPTH);
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   // Width of an operator rank (priority plus one, so it stays unsigned).
   localparam int RANK_W = 3;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Ranks: caret highest, open parenthesis above unknown characters.
   localparam logic [RANK_W-1:0] RANK_POW     = 3'd4;
   localparam logic [RANK_W-1:0] RANK_MUL     = 3'd3;
   localparam logic [RANK_W-1:0] RANK_ADD     = 3'd2;
   localparam logic [RANK_W-1:0] RANK_PAREN   = 3'd1;
   localparam logic [RANK_W-1:0] RANK_UNKNOWN = 3'd0;

   // Command classes decided by the front end.
   typedef enum logic [2:0] {
      CMD_PASS,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_OPER,
      CMD_FLUSH
   } cmd_kind_type;

   // One classified character.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        ch;
      logic [RANK_W-1:0] rank;
   } cmd_type;

   // Head of the command queue as the back end sees it.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   // Rank of a character for the pop comparison.
   function automatic logic [RANK_W-1:0] rank_of(input logic [7:0] c);
      logic [RANK_W-1:0] r;
      case (c)
         CHAR_CARET:             r = RANK_POW;
         CHAR_STAR, CHAR_SLASH:  r = RANK_MUL;
         CHAR_PLUS, CHAR_MINUS:  r = RANK_ADD;
         CHAR_LPAREN:            r = RANK_PAREN;
         default:                r = RANK_UNKNOWN;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/itp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Infix-to-postfix front end
// Accepts input beats, classifies each character and queues the command for
// the back end.
// ----------------------------------------------------------------------------
module itp_front
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_char,
   output q_head_type      q_head,
   input  wire logic       q_pop
);

   cmd_type        q_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] q_count_ff, q_count_in;
   cmd_type        cmd_new;
   logic           accept;
   logic           is_alnum;

   // Classify the incoming character.
   always_comb begin
      is_alnum = ((req_in_char >= 8'h30) && (req_in_char <= 8'h39)) ||
                 ((req_in_char >= 8'h61) && (req_in_char <= 8'h7A)) ||
                 ((req_in_char >= 8'h41) && (req_in_char <= 8'h5A));
      cmd_new.ch   = req_in_char;
      cmd_new.rank = rank_of(req_in_char);
      if (req_in_char == CHAR_NUL) begin
         cmd_new.kind = CMD_FLUSH;
      end else if (is_alnum) begin
         cmd_new.kind = CMD_PASS;
      end else if (req_in_char == CHAR_LPAREN) begin
         cmd_new.kind = CMD_OPEN;
      end else if (req_in_char == CHAR_RPAREN) begin
         cmd_new.kind = CMD_CLOSE;
      end else begin
         cmd_new.kind = CMD_OPER;
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      req_stall  = (q_count_ff == QCW'(QUEUE_DEPTH));
      accept     = req_valid && !req_stall;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      q_count_in = q_count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (accept && !q_pop) begin
         q_count_in = q_count_ff + QCW'(1);
      end else if (!accept && q_pop) begin
         q_count_in = q_count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   // The head entry is offered to the back end.
   always_comb begin
      q_head.valid = (q_count_ff != '0);
      q_head.cmd   = q_ff[rd_ptr_ff];
   end

endmodule
`default_nettype wire

>>> src/itp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Infix-to-postfix back end
// Runs queued commands on the operator stack and drives the registered result
// channel, one push, pop or emit per cycle while no emit waits on rsp_stall.
// ----------------------------------------------------------------------------
module itp_back
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire q_head_type  q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_overflow
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]    stack_mem [STACK_DEPTH];
   logic [7:0]    top_ff;
   logic [7:0]    second_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_char_ff;
   logic          rsp_last_ff;
   logic          rsp_ovf_ff;

   cmd_type       cmd;
   logic          out_free;
   logic          has_top;
   logic          has_two;
   logic          do_emit;
   logic [7:0]    emit_char;
   logic          emit_last;
   logic          do_pop;
   logic          do_push;
   logic          do_clear;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd1_addr;
   logic [AW-1:0] rd2_addr;

   // Decide this cycle's single action for the command at the queue head.
   always_comb begin
      cmd       = q_head.cmd;
      out_free  = !rsp_valid_ff || !rsp_stall;
      has_top   = (count_ff != '0);
      has_two   = (count_ff >= CW'(2));
      q_pop     = 1'b0;
      do_emit   = 1'b0;
      emit_char = cmd.ch;
      emit_last = 1'b0;
      do_pop    = 1'b0;
      do_push   = 1'b0;
      do_clear  = 1'b0;
      overflow_in = overflow_ff;
      if (q_head.valid) begin
         case (cmd.kind)
            CMD_PASS: begin
               if (out_free) begin
                  do_emit   = 1'b1;
                  emit_last = 1'b1;
                  q_pop     = 1'b1;
               end
            end
            CMD_OPEN: begin
               if (count_ff == CW'(STACK_DEPTH)) begin
                  overflow_in = 1'b1;
               end else begin
                  do_push = 1'b1;
               end
               q_pop = 1'b1;
            end
            CMD_CLOSE: begin
               if (has_top && (top_ff != CHAR_LPAREN)) begin
                  if (out_free) begin
                     do_emit   = 1'b1;
                     emit_char = top_ff;
                     emit_last = !has_two || (second_ff == CHAR_LPAREN);
                     do_pop    = 1'b1;
                  end
               end else begin
                  // Discard the matching open parenthesis if there is one.
                  do_pop = has_top;
                  q_pop  = 1'b1;
               end
            end
            CMD_OPER: begin
               if (has_top && (rank_of(top_ff) >= cmd.rank)) begin
                  if (out_free) begin
                     do_emit   = 1'b1;
                     emit_char = top_ff;
                     emit_last = !has_two || (rank_of(second_ff) < cmd.rank);
                     do_pop    = 1'b1;
                  end
               end else begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     overflow_in = 1'b1;
                  end else begin
                     do_push = 1'b1;
                  end
                  q_pop = 1'b1;
               end
            end
            CMD_FLUSH: begin
               if (out_free) begin
                  do_emit = 1'b1;
                  if (has_top) begin
                     emit_char = top_ff;
                     do_pop    = 1'b1;
                  end else begin
                     emit_char = CHAR_NUL;
                     emit_last = 1'b1;
                     do_clear  = 1'b1;
                     overflow_in = 1'b0;
                     q_pop     = 1'b1;
                  end
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end

      // Stack fill count and the addresses of the next top two entries.
      if (do_clear) begin
         count_in = '0;
      end else if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
      wr_addr  = AW'(count_ff);
      rd1_addr = AW'(count_in - CW'(1));
      rd2_addr = AW'(count_in - CW'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Stack memory: one write port, two registered read ports that follow
   // the top two entries. A push bypasses into the top register.
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[wr_addr] <= cmd.ch;
      end
      if (do_push && (wr_addr == rd1_addr)) begin
         top_ff <= cmd.ch;
      end else begin
         top_ff <= stack_mem[rd1_addr];
      end
      second_ff <= stack_mem[rd2_addr];
   end

   // Output register: holds its beat while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
         rsp_ovf_ff  <= overflow_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_run_last = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   // The stack never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("operator stack count above depth");

   // A pop only happens on a non-empty stack.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_pop |-> has_top)
      else $error("pop from empty operator stack");

   // A new result never overwrites a beat that the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      do_emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result beat overwritten while stalled");

   // After the terminator the stack and the overflow flag are clear.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (count_ff == '0) && !overflow_ff)
      else $error("state not cleared after terminator");

endmodule
`default_nettype wire

>>> src/infix_to_postfix_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard conversion of an expression, one character per input beat.
//
// Usage: each req_ beat carries one expression character; each rsp_ beat
// carries one postfix character, with rsp_run_last marking the last result
// caused by an input character and rsp_overflow showing that a push onto the
// full operator stack was dropped since the expression started. A zero
// character flushes the stack and ends with a zero terminator beat.
// A pass-through character is written into the command queue, then emitted
// into the result register. The back end does one push, pop or emit per cycle
// unless an emit waits on rsp_stall: an operator emits and pops each entry
// ranking at least as high, then is pushed; a close parenthesis emits and pops
// each entry down to its open parenthesis and discards it; a zero emits the
// stack and then a terminator. A four-entry command queue sits between the
// front end and the back end; req_stall rises only when that queue is full.
// Reset clears the queue, the stack count, the overflow flag and the result
// register; no clearing pass runs. While rsp_stall holds a beat, the back end
// stops at the next command with a beat to emit; input is taken until the
// queue fills.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_overflow
);

   q_head_type q_head;
   logic       q_pop;

   // Front end: accept and classify characters.
   itp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   // Back end: operator stack and result register.
   itp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .rsp_overflow (rsp_overflow)
   );

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix-to-postfix converter testbench
// Streams expression characters into the converter and checks every postfix
// beat against a shunting-yard predictor kept inside the bench. Directed
// expressions come first, then random expressions (mostly well formed, some
// corrupted, some pure noise, some nested deep enough to drop pushes), with
// random idling on both channels, one long receiver hold-off and two pauses
// in which the sender waits for all outstanding postfix beats.
// ----------------------------------------------------------------------------
module testbench
   import itp_pkg::*;
();

   localparam int STACK_DEPTH = DEF_STACK_DEPTH;
   localparam int IDLE_PCT    = 26;
   localparam int HOLD_CYCLES = 90;
   localparam int HOLD_AFTER  = 60;
   localparam int STUCK_LIMIT = 2000;
   localparam int TAIL_CYCLES = 50;
   localparam int RANDOM_ITEMS = 300;

   // One expected postfix beat.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } postfix_beat_type;

   // One character waiting to be sent, or a marker that makes the sender
   // wait for all outstanding postfix beats.
   typedef struct packed {
      logic       drain_first;
      logic [7:0] ch;
   } char_slot_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_overflow;

   char_slot_type    chars_to_send[$];
   postfix_beat_type postfix_due[$];

   // Predictor state: the operator stack, its fill level and the sticky
   // dropped-push flag.
   logic [7:0] yard_stack [0:STACK_DEPTH-1];
   int         yard_depth = 0;
   logic       dropped_push = 1'b0;

   int mismatches = 0;
   int cycle_no = 0;
   logic calm;

   infix_to_postfix_converter_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .rsp_overflow (rsp_overflow)
   );

   always #1 clock = ~clock;

   // Cycle count; a window in the middle of the run has no idling at all.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end
   assign calm = (cycle_no >= 250) && (cycle_no < 450);

   task automatic report_mismatch(input string field, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t ns: %s got %02h want %02h", $time, field, got, want);
      mismatches++;
   endtask

   function automatic int op_rank(input logic [7:0] c);
      case (c)
         CHAR_CARET:            return 3;
         CHAR_STAR, CHAR_SLASH: return 2;
         CHAR_PLUS, CHAR_MINUS: return 1;
         CHAR_LPAREN:           return 0;
         default:               return -1;
      endcase
   endfunction

   function automatic postfix_beat_type beat_of(input logic [7:0] c, input logic o);
      postfix_beat_type b;
      b.ch   = c;
      b.last = 1'b0;
      b.ovf  = o;
      return b;
   endfunction

   // Shunting-yard step for one accepted character; appends its postfix beats.
   task automatic convert_char(input logic [7:0] c);
      postfix_beat_type beats[$];
      int               r;
      if (c == CHAR_NUL) begin
         while (yard_depth > 0) begin
            yard_depth--;
            beats.push_back(beat_of(yard_stack[yard_depth], dropped_push));
         end
         beats.push_back(beat_of(CHAR_NUL, dropped_push));
         dropped_push = 1'b0;
      end else if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z")) begin
         beats.push_back(beat_of(c, dropped_push));
      end else if (c == CHAR_RPAREN) begin
         while (yard_depth > 0 && yard_stack[yard_depth-1] != CHAR_LPAREN) begin
            yard_depth--;
            beats.push_back(beat_of(yard_stack[yard_depth], dropped_push));
         end
         if (yard_depth > 0) yard_depth--;
      end else begin
         // An open parenthesis is pushed without popping; operators and
         // unknown characters pop while the top ranks at least as high.
         if (c != CHAR_LPAREN) begin
            r = op_rank(c);
            while (yard_depth > 0 && op_rank(yard_stack[yard_depth-1]) >= r) begin
               yard_depth--;
               beats.push_back(beat_of(yard_stack[yard_depth], dropped_push));
            end
         end
         if (yard_depth >= STACK_DEPTH) begin
            dropped_push = 1'b1;
         end else begin
            yard_stack[yard_depth] = c;
            yard_depth++;
         end
      end
      if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) postfix_due.push_back(beats[i]);
   endtask

   // Request driver: hold a stalled beat, otherwise load the next character.
   always @(posedge clock) begin : drive_req
      logic       go;
      logic [7:0] nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         go  = req_valid;
         nxt = req_in_char;
         if (req_valid && !req_stall) begin
            convert_char(req_in_char);
            go = 1'b0;
         end
         if (!go && chars_to_send.size() > 0) begin
            if (chars_to_send[0].drain_first) begin
               if (postfix_due.size() == 0) void'(chars_to_send.pop_front());
            end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
               nxt = chars_to_send[0].ch;
               void'(chars_to_send.pop_front());
               go = 1'b1;
            end
         end
         req_valid   <= go;
         req_in_char <= nxt;
      end
   end

   // Response monitor: check each beat, then pick the next stall value.
   always @(posedge clock) begin : watch_rsp
      int               beats_seen;
      int               hold_left;
      logic             hold_done;
      postfix_beat_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         beats_seen = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (postfix_due.size() == 0) begin
               report_mismatch("unexpected beat, out_char", rsp_out_char, 8'h00);
            end else begin
               want = postfix_due.pop_front();
               if (rsp_out_char !== want.ch)
                  report_mismatch("out_char", rsp_out_char, want.ch);
               if (rsp_run_last !== want.last)
                  report_mismatch("run_last", {7'b0, rsp_run_last}, {7'b0, want.last});
               if (rsp_overflow !== want.ovf)
                  report_mismatch("overflow", {7'b0, rsp_overflow}, {7'b0, want.ovf});
            end
         end
         // One long hold-off so the command queue fills and req_stall rises.
         if (!hold_done && beats_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin : watchdog
      int stuck;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck = 0;
      end else begin
         stuck++;
         if (stuck >= STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Queue one character, replaced by a random byte at the given rate.
   task automatic put(input logic [7:0] c, input int noise_pct);
      char_slot_type s;
      s.drain_first = 1'b0;
      s.ch          = ($urandom_range(99) < noise_pct) ? 8'($urandom_range(255)) : c;
      chars_to_send.push_back(s);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i], 0);
   endtask

   task automatic put_drain();
      char_slot_type s;
      s.drain_first = 1'b1;
      s.ch          = CHAR_NUL;
      chars_to_send.push_back(s);
   endtask

   function automatic logic [7:0] pick_operand();
      int r;
      r = $urandom_range(61);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("a" + r - 10);
      return 8'("A" + r - 36);
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(4))
         0:       return CHAR_CARET;
         1:       return CHAR_STAR;
         2:       return CHAR_SLASH;
         3:       return CHAR_PLUS;
         default: return CHAR_MINUS;
      endcase
   endfunction

   // Random infix expression ending in the terminator; nest opens extra
   // parentheses up front so the operator stack can overrun.
   task automatic put_expression(input int terms, input int nest, input int noise_pct);
      int depth;
      depth = 0;
      for (int i = 0; i < nest; i++) put(CHAR_LPAREN, 0);
      for (int t = 0; t < terms; t++) begin
         while ($urandom_range(3) == 0 && depth < 6) begin
            put(CHAR_LPAREN, noise_pct);
            depth++;
         end
         put(pick_operand(), noise_pct);
         while (depth > 0 && $urandom_range(2) == 0) begin
            put(CHAR_RPAREN, noise_pct);
            depth--;
         end
         if (t < terms - 1) put(pick_operator(), noise_pct);
      end
      for (int i = 0; i < depth + nest; i++) begin
         if ($urandom_range(3) != 0) put(CHAR_RPAREN, noise_pct);
      end
      put(CHAR_NUL, 0);
   endtask

   initial begin : stimulus
      int sel;
      int goal;
      logic drained;

      // Directed: every operator, the field extremes, an unknown character
      // that pops an open parenthesis, an unmatched close and a repeated caret.
      put_text("A*(z+9)^2/1-0");
      put(CHAR_NUL, 0);
      put_text("(a");
      put(8'hFF, 0);
      put_text(")^^b");
      put(CHAR_NUL, 0);
      put(8'h01, 0);
      put(CHAR_NUL, 0);
      put_drain();

      // Random expressions.
      goal    = chars_to_send.size() + RANDOM_ITEMS;
      drained = 1'b0;
      while (chars_to_send.size() < goal) begin
         sel = $urandom_range(99);
         if (sel < 10) begin
            put_expression($urandom_range(1, 5), $urandom_range(28, 40), 0);
         end else if (sel < 78) begin
            put_expression($urandom_range(1, 8), 0, 0);
         end else if (sel < 90) begin
            put_expression($urandom_range(1, 8), 0, 15);
         end else begin
            repeat ($urandom_range(1, 8)) put(8'($urandom_range(255)), 0);
            put(CHAR_NUL, 0);
         end
         if (!drained && chars_to_send.size() > goal / 2) begin
            put_drain();
            drained = 1'b1;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every character is taken and every beat has come back.
      @(negedge clock);
      while (chars_to_send.size() > 0 || req_valid || postfix_due.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0 && postfix_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
